// ===== sv/nst_pkg.sv =====
// ----------------------------------------------------------------------------
// nst_pkg
// Shared constants, codes and controller/datapath interface types for the
// named semaphore table unit.
// ----------------------------------------------------------------------------
package nst_pkg;

   // table geometry
   localparam int NUM_SEMS  = 16;
   localparam int NUM_PROCS = 32;
   localparam int KEY_BITS  = 16;

   localparam int IDX_W = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
   localparam int PID_W = $clog2(NUM_PROCS);

   // port field widths
   localparam int OPCODE_W     = 3;
   localparam int SEM_KEY_W    = 16;
   localparam int CALLER_PID_W = 5;
   localparam int COUNT_W      = 32;
   localparam int STATUS_W     = 3;

   typedef enum logic [OPCODE_W-1:0] {
      OP_OPEN   = 3'd0,
      OP_WAIT   = 3'd1,
      OP_POST   = 3'd2,
      OP_CLOSE  = 3'd3,
      OP_DELETE = 3'd4
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK         = 3'd0,
      ST_CREATED    = 3'd1,
      ST_NOT_FOUND  = 3'd2,
      ST_NOT_MEMBER = 3'd3,
      ST_TABLE_FULL = 3'd4
   } status_type;

   // entry update selected by the controller during execute
   typedef enum logic [3:0] {
      ACT_NONE,
      ACT_JOIN,
      ACT_CREATE,
      ACT_TAKE,
      ACT_ENQUEUE,
      ACT_HANDOFF,
      ACT_INCR,
      ACT_LEAVE,
      ACT_FREE
   } action_type;

   typedef struct packed {
      logic       load;
      logic       lookup;
      logic       execute;
      action_type action;
      status_type status;
   } nst_cmd_type;

   typedef struct packed {
      logic [OPCODE_W-1:0] opcode;
      logic                hit;
      logic                full;
      logic                count_zero;
      logic                is_member;
      logic                q_nonempty;
   } nst_stat_type;

   // process ids at or above NUM_PROCS wrap
   function automatic logic [PID_W-1:0] pid_reduce(input logic [CALLER_PID_W-1:0] p);
      pid_reduce = PID_W'(p % NUM_PROCS);
   endfunction

endpackage

// ===== sv/nst_ctrl.sv =====
// ----------------------------------------------------------------------------
// nst_ctrl
// Request sequencer: accept, key match, execute. Decodes the opcode and the
// entry status into one entry update and the response status code.
// ----------------------------------------------------------------------------
module nst_ctrl import nst_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  nst_stat_type stat,
   output nst_cmd_type  cmd
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_MATCH,
      S_EXEC
   } state_type;

   state_type  state_ff;
   state_type  state_in;
   logic       busy_ff;
   logic       accept;
   action_type action;
   status_type status;

   assign busy   = busy_ff;
   assign accept = start && !busy_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:  state_in = accept ? S_MATCH : S_IDLE;
         S_MATCH: state_in = S_EXEC;
         S_EXEC:  state_in = accept ? S_MATCH : S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         busy_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= (state_in == S_MATCH);
      end
   end

   // operation decode, meaningful in the execute cycle
   always_comb begin
      action = ACT_NONE;
      status = ST_OK;
      case (stat.opcode)
         OP_OPEN: begin
            if (stat.hit) begin
               action = ACT_JOIN;
            end else if (stat.full) begin
               status = ST_TABLE_FULL;
            end else begin
               action = ACT_CREATE;
               status = ST_CREATED;
            end
         end
         OP_WAIT: begin
            if (!stat.hit)
               status = ST_NOT_FOUND;
            else
               action = stat.count_zero ? ACT_ENQUEUE : ACT_TAKE;
         end
         OP_POST: begin
            if (!stat.hit)
               status = ST_NOT_FOUND;
            else
               action = stat.q_nonempty ? ACT_HANDOFF : ACT_INCR;
         end
         OP_CLOSE: begin
            if (!stat.hit)
               status = ST_NOT_FOUND;
            else if (!stat.is_member)
               status = ST_NOT_MEMBER;
            else
               action = ACT_LEAVE;
         end
         OP_DELETE: begin
            if (!stat.hit)
               status = ST_NOT_FOUND;
            else
               action = ACT_FREE;
         end
         default: begin
            action = ACT_NONE;
            status = ST_OK;
         end
      endcase
   end

   always_comb begin
      cmd.load    = accept;
      cmd.lookup  = (state_ff == S_MATCH);
      cmd.execute = (state_ff == S_EXEC);
      cmd.action  = action;
      cmd.status  = status;
   end

endmodule

// ===== sv/nst_dp.sv =====
// ----------------------------------------------------------------------------
// nst_dp
// Semaphore table storage, key match, entry read-modify-write and the
// response registers.
// ----------------------------------------------------------------------------
module nst_dp import nst_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  nst_cmd_type             cmd,
   output nst_stat_type            stat,
   input  logic [OPCODE_W-1:0]     req_opcode,
   input  logic [SEM_KEY_W-1:0]    req_sem_key,
   input  logic [CALLER_PID_W-1:0] req_caller_pid,
   input  logic [COUNT_W-1:0]      req_init_count,
   output logic                    rsp_valid,
   output logic [STATUS_W-1:0]     rsp_status,
   output logic                    rsp_caller_blocks,
   output logic                    rsp_wake_valid,
   output logic [CALLER_PID_W-1:0] rsp_wake_pid
);

   // table
   logic [NUM_SEMS-1:0]  entry_valid_ff;
   logic [KEY_BITS-1:0]  entry_key_ff   [NUM_SEMS];
   logic [COUNT_W-1:0]   entry_count_ff [NUM_SEMS];
   logic [NUM_PROCS-1:0] member_map_ff  [NUM_SEMS];
   logic [PID_W-1:0]     waitq_head_ff  [NUM_SEMS];
   logic [PID_W-1:0]     waitq_tail_ff  [NUM_SEMS];
   logic [NUM_SEMS-1:0]  waitq_nonempty_ff;
   logic [PID_W-1:0]     next_waiter_ff [NUM_PROCS];

   // captured request
   logic [OPCODE_W-1:0] opcode_ff;
   logic [KEY_BITS-1:0] key_ff;
   logic [PID_W-1:0]    pid_ff;
   logic [COUNT_W-1:0]  init_ff;

   // match results
   logic [IDX_W-1:0] idx_ff;
   logic [IDX_W-1:0] idx_in;
   logic             hit_ff;
   logic             hit_in;
   logic             full_ff;
   logic             full_in;

   // response
   logic                    rsp_valid_ff;
   logic [STATUS_W-1:0]     rsp_status_ff;
   logic                    rsp_blocks_ff;
   logic                    rsp_wake_ff;
   logic [CALLER_PID_W-1:0] rsp_pid_ff;

   // selected entry
   logic [COUNT_W-1:0]   count_rd;
   logic [NUM_PROCS-1:0] member_rd;
   logic [PID_W-1:0]     head_rd;
   logic [PID_W-1:0]     tail_rd;
   logic                 nonempty_rd;
   logic [NUM_PROCS-1:0] pid_bit;
   logic [NUM_PROCS-1:0] member_left;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         opcode_ff <= req_opcode;
         key_ff    <= KEY_BITS'(req_sem_key);
         pid_ff    <= pid_reduce(req_caller_pid);
         init_ff   <= req_init_count;
      end
   end

   // key match and lowest free slot; lowest index wins
   always_comb begin
      idx_in  = '0;
      hit_in  = 1'b0;
      full_in = 1'b1;
      for (int i = NUM_SEMS - 1; i >= 0; i--) begin
         if (!entry_valid_ff[i]) begin
            full_in = 1'b0;
            if (!hit_in)
               idx_in = IDX_W'(i);
         end
      end
      for (int i = NUM_SEMS - 1; i >= 0; i--) begin
         if (entry_valid_ff[i] && entry_key_ff[i] == key_ff) begin
            hit_in = 1'b1;
            idx_in = IDX_W'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.lookup) begin
         idx_ff  <= idx_in;
         hit_ff  <= hit_in;
         full_ff <= full_in;
      end
   end

   assign count_rd    = entry_count_ff[idx_ff];
   assign member_rd   = member_map_ff[idx_ff];
   assign head_rd     = waitq_head_ff[idx_ff];
   assign tail_rd     = waitq_tail_ff[idx_ff];
   assign nonempty_rd = waitq_nonempty_ff[idx_ff];
   assign pid_bit     = NUM_PROCS'(1) << pid_ff;
   assign member_left = member_rd & ~pid_bit;

   always_comb begin
      stat.opcode     = opcode_ff;
      stat.hit        = hit_ff;
      stat.full       = full_ff;
      stat.count_zero = (count_rd == '0);
      stat.is_member  = member_rd[pid_ff];
      stat.q_nonempty = nonempty_rd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= '0;
      end else if (cmd.execute) begin
         case (cmd.action)
            ACT_CREATE: entry_valid_ff[idx_ff] <= 1'b1;
            ACT_LEAVE:  if (member_left == '0) entry_valid_ff[idx_ff] <= 1'b0;
            ACT_FREE:   entry_valid_ff[idx_ff] <= 1'b0;
            default:    ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         case (cmd.action)
            ACT_JOIN: member_map_ff[idx_ff] <= member_rd | pid_bit;
            ACT_CREATE: begin
               entry_key_ff[idx_ff]      <= key_ff;
               entry_count_ff[idx_ff]    <= init_ff;
               member_map_ff[idx_ff]     <= pid_bit;
               waitq_nonempty_ff[idx_ff] <= 1'b0;
            end
            ACT_TAKE: entry_count_ff[idx_ff] <= count_rd - COUNT_W'(1);
            ACT_ENQUEUE: begin
               if (nonempty_rd)
                  next_waiter_ff[tail_rd] <= pid_ff;
               else
                  waitq_head_ff[idx_ff] <= pid_ff;
               waitq_tail_ff[idx_ff]     <= pid_ff;
               waitq_nonempty_ff[idx_ff] <= 1'b1;
            end
            ACT_HANDOFF: begin
               if (head_rd == tail_rd)
                  waitq_nonempty_ff[idx_ff] <= 1'b0;
               else
                  waitq_head_ff[idx_ff] <= next_waiter_ff[head_rd];
            end
            ACT_INCR: begin
               if (count_rd != '1)
                  entry_count_ff[idx_ff] <= count_rd + COUNT_W'(1);
            end
            ACT_LEAVE: member_map_ff[idx_ff] <= member_left;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset)
         rsp_valid_ff <= 1'b0;
      else
         rsp_valid_ff <= cmd.execute;
   end

   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         rsp_status_ff <= cmd.status;
         rsp_blocks_ff <= (cmd.action == ACT_ENQUEUE);
         rsp_wake_ff   <= (cmd.action == ACT_HANDOFF);
         rsp_pid_ff    <= (cmd.action == ACT_HANDOFF) ? CALLER_PID_W'(head_rd) : '0;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_caller_blocks = rsp_blocks_ff;
   assign rsp_wake_valid    = rsp_wake_ff;
   assign rsp_wake_pid      = rsp_pid_ff;

endmodule

// ===== sv/named_semaphore_table_unit.sv =====
// ----------------------------------------------------------------------------
// named_semaphore_table_unit
// Table of named counting semaphores with per-entry membership and a FIFO
// of blocked waiters; open, wait, post, close and delete requests.
// ----------------------------------------------------------------------------
// A request transfers at a rising edge with start high and busy low. It
// runs a key compare across all table entries, then a read-modify-write
// of the selected entry. busy is high only during the key compare, so
// the next request may transfer during the read-modify-write of the
// last one. The response is registered by that step and appears on
// rsp_valid for exactly one cycle; the receiver cannot stall it and must
// take it in that cycle. No clearing pass is needed after reset: only the
// entry valid bits are reset, and entry contents are written before use.
// ----------------------------------------------------------------------------
module named_semaphore_table_unit import nst_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   // request
   input  logic                    start,
   output logic                    busy,
   input  logic [OPCODE_W-1:0]     req_opcode,
   input  logic [SEM_KEY_W-1:0]    req_sem_key,
   input  logic [CALLER_PID_W-1:0] req_caller_pid,
   input  logic [COUNT_W-1:0]      req_init_count,
   // response strobe and fields
   output logic                    rsp_valid,
   output logic [STATUS_W-1:0]     rsp_status,
   output logic                    rsp_caller_blocks,
   output logic                    rsp_wake_valid,
   output logic [CALLER_PID_W-1:0] rsp_wake_pid
);

   nst_cmd_type  cmd;   // controller -> datapath
   nst_stat_type stat;  // datapath -> controller

   // sequencing and opcode decode
   nst_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   // table, key match, entry update, response registers
   nst_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_opcode        (req_opcode),
      .req_sem_key       (req_sem_key),
      .req_caller_pid    (req_caller_pid),
      .req_init_count    (req_init_count),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_caller_blocks (rsp_caller_blocks),
      .rsp_wake_valid    (rsp_wake_valid),
      .rsp_wake_pid      (rsp_wake_pid)
   );

endmodule

// ===== sv/nst_checker.sv =====
// ----------------------------------------------------------------------------
// nst_checker
// Port-level timing and response consistency checks, bound to the top level.
// ----------------------------------------------------------------------------
module nst_checker import nst_pkg::*; (
   input logic                    clock,
   input logic                    reset,
   input logic                    start,
   input logic                    busy,
   input logic                    rsp_valid,
   input logic [STATUS_W-1:0]     rsp_status,
   input logic                    rsp_caller_blocks,
   input logic                    rsp_wake_valid,
   input logic [CALLER_PID_W-1:0] rsp_wake_pid
);

   // every transfer gets its response strobe
   a_rsp_after_req: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##3 rsp_valid)
      else $error("response missing three cycles after request");

   // busy covers exactly the cycle after a transfer
   a_busy_one_cycle: assert property (@(posedge clock) disable iff (reset)
      busy |=> !busy)
      else $error("busy held longer than one cycle");

   // no response without a request: busy high in its key compare, low in its execute
   a_rsp_has_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(busy, 2) && !$past(busy, 1)))
      else $error("response without a preceding request");

   // a blocked wait neither wakes anyone nor reports an error
   a_block_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_caller_blocks) |-> (!rsp_wake_valid && rsp_status == ST_OK))
      else $error("blocking response with wake or error status");

   // a wake only comes with ok status; no wake means pid zero
   a_wake_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_wake_valid ? (rsp_status == ST_OK) : (rsp_wake_pid == '0)))
      else $error("inconsistent wake fields");

endmodule

bind named_semaphore_table_unit nst_checker u_nst_checker (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .rsp_valid         (rsp_valid),
   .rsp_status        (rsp_status),
   .rsp_caller_blocks (rsp_caller_blocks),
   .rsp_wake_valid    (rsp_wake_valid),
   .rsp_wake_pid      (rsp_wake_pid)
);

// ===== dv/tb_named_semaphore_table_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_named_semaphore_table_unit
// Self-checking bench for the named semaphore table. A queue of requests
// (directed corner cases, then phases of random traffic over small key and
// pid pools) feeds a clocked driver. Each transfer is run through a local
// model of the table, and a clocked monitor compares every response strobe
// field by field against the oldest predicted response.
// ----------------------------------------------------------------------------
module tb_named_semaphore_table_unit;
   import nst_pkg::*;

   localparam int unsigned RANDOM_ITEMS = 1900;
   localparam int unsigned CYCLE_LIMIT  = 250000;
   localparam int unsigned DRAIN_CYCLES = 8;
   localparam logic [SEM_KEY_W-1:0] KEY_MASK =
      (KEY_BITS >= SEM_KEY_W) ? '1 : SEM_KEY_W'((64'd1 << KEY_BITS) - 64'd1);

   typedef struct {
      logic [OPCODE_W-1:0]     opcode;
      logic [SEM_KEY_W-1:0]    sem_key;
      logic [CALLER_PID_W-1:0] caller_pid;
      logic [COUNT_W-1:0]      init_count;
      int unsigned             gap;    // idle cycles before this request
      bit                      hold;   // wait for all responses before issuing
   } sem_request_type;

   typedef struct packed {
      status_type              status;
      logic                    caller_blocks;
      logic                    wake_valid;
      logic [CALLER_PID_W-1:0] wake_pid;
   } sem_response_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                    start          = 1'b0;
   logic                    busy;
   logic [OPCODE_W-1:0]     req_opcode     = '0;
   logic [SEM_KEY_W-1:0]    req_sem_key    = '0;
   logic [CALLER_PID_W-1:0] req_caller_pid = '0;
   logic [COUNT_W-1:0]      req_init_count = '0;
   logic                    rsp_valid;
   logic [STATUS_W-1:0]     rsp_status;
   logic                    rsp_caller_blocks;
   logic                    rsp_wake_valid;
   logic [CALLER_PID_W-1:0] rsp_wake_pid;

   sem_request_type  pending_requests[$];
   sem_response_type expected_responses[$];

   // transfer counters, both updated with NBAs so either side can read them
   // at the clock edge without depending on process order
   int unsigned issued       = 0;
   int unsigned retired      = 0;
   int unsigned idle_left    = 0;
   int unsigned cycle_count  = 0;
   int unsigned failures     = 0;

   // model of the semaphore table
   bit                      tbl_valid   [NUM_SEMS];
   bit [SEM_KEY_W-1:0]      tbl_key     [NUM_SEMS];
   bit [COUNT_W-1:0]        tbl_count   [NUM_SEMS];
   bit [NUM_PROCS-1:0]      tbl_members [NUM_SEMS];
   bit [PID_W-1:0]          q_head      [NUM_SEMS];
   bit [PID_W-1:0]          q_tail      [NUM_SEMS];
   bit                      q_nonempty  [NUM_SEMS];
   bit [PID_W-1:0]          waiter_link [NUM_PROCS];   // shared by all entries

   named_semaphore_table_unit i_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_opcode        (req_opcode),
      .req_sem_key       (req_sem_key),
      .req_caller_pid    (req_caller_pid),
      .req_init_count    (req_init_count),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_caller_blocks (rsp_caller_blocks),
      .rsp_wake_valid    (rsp_wake_valid),
      .rsp_wake_pid      (rsp_wake_pid)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // --------------------------------------------------------------------------
   // Semaphore table model: applies one request and returns its response.
   // --------------------------------------------------------------------------
   function automatic sem_response_type apply_sem_request(
      input logic [OPCODE_W-1:0]     op,
      input logic [SEM_KEY_W-1:0]    key_in,
      input logic [CALLER_PID_W-1:0] pid_in,
      input logic [COUNT_W-1:0]      init);
      sem_response_type   rsp;
      logic [SEM_KEY_W-1:0] key;
      logic [PID_W-1:0]   pid;
      logic [NUM_PROCS-1:0] pid_bit;
      int                 hit;
      int                 slot;
      logic [PID_W-1:0]   head;
      rsp     = '0;
      key     = key_in & KEY_MASK;
      pid     = PID_W'(pid_in % NUM_PROCS);
      pid_bit = NUM_PROCS'(1) << pid;
      hit     = -1;
      slot    = -1;
      for (int i = 0; i < NUM_SEMS; i++) begin
         if (hit < 0 && tbl_valid[i] && tbl_key[i] == key) hit = i;
         if (slot < 0 && !tbl_valid[i]) slot = i;
      end

      if (op == OP_OPEN) begin
         if (hit >= 0) begin
            // joining, or already a member: membership just gets the bit
            tbl_members[hit] |= pid_bit;
         end else if (slot < 0) begin
            rsp.status = ST_TABLE_FULL;
         end else begin
            tbl_valid[slot]   = 1'b1;
            tbl_key[slot]     = key;
            tbl_count[slot]   = init;
            tbl_members[slot] = pid_bit;
            q_nonempty[slot]  = 1'b0;
            rsp.status        = ST_CREATED;
         end
      end else if (op > OP_DELETE) begin
         // unknown opcode: ignored, all-zero response
      end else if (hit < 0) begin
         rsp.status = ST_NOT_FOUND;
      end else begin
         case (op)
            OP_WAIT: begin
               if (tbl_count[hit] != 0) begin
                  tbl_count[hit]--;
               end else begin
                  // queue the caller; a caller already queued relinks its
                  // shared pointer, exactly as written
                  if (q_nonempty[hit]) waiter_link[q_tail[hit]] = pid;
                  else q_head[hit] = pid;
                  q_tail[hit]       = pid;
                  q_nonempty[hit]   = 1'b1;
                  rsp.caller_blocks = 1'b1;
               end
            end
            OP_POST: begin
               if (q_nonempty[hit]) begin
                  // direct hand-off: count untouched
                  head           = q_head[hit];
                  rsp.wake_valid = 1'b1;
                  rsp.wake_pid   = CALLER_PID_W'(head);
                  if (head == q_tail[hit]) q_nonempty[hit] = 1'b0;
                  else q_head[hit] = waiter_link[head];
               end else if (tbl_count[hit] != '1) begin
                  tbl_count[hit]++;
               end
            end
            OP_CLOSE: begin
               if ((tbl_members[hit] & pid_bit) == '0) begin
                  rsp.status = ST_NOT_MEMBER;
               end else begin
                  tbl_members[hit] &= ~pid_bit;
                  if (tbl_members[hit] == '0) tbl_valid[hit] = 1'b0;
               end
            end
            default: tbl_valid[hit] = 1'b0;   // delete drops any waiters
         endcase
      end
      return rsp;
   endfunction

   // random idle length: mode 0 never idles, otherwise mostly short gaps
   function automatic int unsigned pick_gap(input int mode);
      int r;
      r = $urandom_range(0, 99);
      if (mode == 0 || r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 8);
      return $urandom_range(20, 60);
   endfunction

   task automatic add_request(input logic [OPCODE_W-1:0] op,
                              input logic [SEM_KEY_W-1:0] key,
                              input logic [CALLER_PID_W-1:0] pid,
                              input logic [COUNT_W-1:0] init,
                              input int unsigned gap,
                              input bit hold);
      sem_request_type req;
      req.opcode     = op;
      req.sem_key    = key;
      req.caller_pid = pid;
      req.init_count = init;
      req.gap        = gap;
      req.hold       = hold;
      pending_requests.push_back(req);
   endtask

   // --------------------------------------------------------------------------
   // Driver: a transfer happens at an edge with start high and busy low. The
   // request is modeled right there; then the next one is driven after its
   // idle gap. A held request waits until every issued response is back.
   // --------------------------------------------------------------------------
   always @(posedge clock) begin : drive_requests
      logic            fire;
      sem_request_type next_req;
      if (reset) begin
         start     <= 1'b0;
         idle_left <= 0;
      end else begin
         fire = start && !busy;
         if (fire) begin
            expected_responses.push_back(apply_sem_request(req_opcode, req_sem_key,
                                                           req_caller_pid,
                                                           req_init_count));
            issued <= issued + 1;
         end
         if (start && !fire) begin
            // busy: request stays on the bus unchanged
         end else if (idle_left != 0) begin
            start     <= 1'b0;
            idle_left <= idle_left - 1;
         end else if (pending_requests.size() != 0 &&
                      (!pending_requests[0].hold || (!fire && issued == retired))) begin
            next_req       = pending_requests.pop_front();
            start          <= 1'b1;
            req_opcode     <= next_req.opcode;
            req_sem_key    <= next_req.sem_key;
            req_caller_pid <= next_req.caller_pid;
            req_init_count <= next_req.init_count;
            idle_left      <= (pending_requests.size() != 0) ? pending_requests[0].gap : 0;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // --------------------------------------------------------------------------
   // Monitor: a response lives for one cycle only; it is checked against the
   // oldest prediction at the edge that ends that cycle.
   // --------------------------------------------------------------------------
   always @(posedge clock) begin : check_responses
      sem_response_type want;
      if (!reset && rsp_valid) begin
         if (expected_responses.size() == 0) begin
            $error("response with no request outstanding: status %0d", rsp_status);
            failures++;
         end else begin
            want = expected_responses.pop_front();
            retired <= retired + 1;
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               failures++;
            end
            if (rsp_caller_blocks !== want.caller_blocks) begin
               $error("caller_blocks: expected %0d, got %0d",
                      want.caller_blocks, rsp_caller_blocks);
               failures++;
            end
            if (rsp_wake_valid !== want.wake_valid) begin
               $error("wake_valid: expected %0d, got %0d", want.wake_valid, rsp_wake_valid);
               failures++;
            end
            if (rsp_wake_pid !== want.wake_pid) begin
               $error("wake_pid: expected %0d, got %0d", want.wake_pid, rsp_wake_pid);
               failures++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("named_semaphore_table_unit test failed");
         $finish;
      end
   end

   // --------------------------------------------------------------------------
   // Stimulus, reset and end of test
   // --------------------------------------------------------------------------
   initial begin : run_test
      logic [SEM_KEY_W-1:0]    key_pool [24];
      logic [CALLER_PID_W-1:0] pid_pool [8];
      logic [OPCODE_W-1:0]     op;
      logic [SEM_KEY_W-1:0]    key;
      logic [CALLER_PID_W-1:0] pid;
      logic [COUNT_W-1:0]      init;
      int unsigned counted;
      int unsigned phase_left;
      int          phase;
      int          gap_mode;
      int          num_keys;
      int          num_pids;
      int          r;
      int          wait_cycles;
      bit          drain_next;

      // directed: missing key on every op, create/join, FIFO hand-off with a
      // relinked waiter, saturation, close by non-member, freeing on the last
      // close, delete, unknown opcodes, reuse of a freed slot
      add_request(OP_WAIT,   16'h1234, 5'd3,  32'd0,        pick_gap(1), 1'b0);
      add_request(OP_POST,   16'h1234, 5'd3,  32'd0,        pick_gap(1), 1'b0);
      add_request(OP_CLOSE,  16'h1234, 5'd3,  32'd0,        pick_gap(1), 1'b0);
      add_request(OP_DELETE, 16'h1234, 5'd3,  32'd0,        pick_gap(1), 1'b0);
      add_request(OP_OPEN,   16'h0000, 5'd0,  32'd0,        pick_gap(1), 1'b0);
      add_request(OP_OPEN,   16'h0000, 5'd31, 32'hFFFFFFFF, pick_gap(1), 1'b0);
      add_request(OP_OPEN,   16'h0000, 5'd0,  32'd7,        pick_gap(1), 1'b0);
      add_request(OP_WAIT,   16'h0000, 5'd5,  32'd0,        pick_gap(1), 1'b0);
      add_request(OP_WAIT,   16'h0000, 5'd6,  32'd0,        pick_gap(1), 1'b0);
      add_request(OP_WAIT,   16'h0000, 5'd5,  32'd0,        pick_gap(1), 1'b0);
      add_request(OP_POST,   16'h0000, 5'd1,  32'd0,        pick_gap(1), 1'b0);
      add_request(OP_POST,   16'h0000, 5'd1,  32'd0,        pick_gap(1), 1'b0);
      add_request(OP_POST,   16'h0000, 5'd1,  32'd0,        pick_gap(1), 1'b0);
      add_request(OP_POST,   16'h0000, 5'd1,  32'd0,        pick_gap(1), 1'b0);
      add_request(OP_WAIT,   16'h0000, 5'd9,  32'd0,        pick_gap(1), 1'b0);
      add_request(OP_OPEN,   16'hFFFF, 5'd1,  32'hFFFFFFFF, pick_gap(1), 1'b0);
      add_request(OP_POST,   16'hFFFF, 5'd1,  32'd0,        pick_gap(1), 1'b0);
      add_request(OP_WAIT,   16'hFFFF, 5'd30, 32'd0,        pick_gap(1), 1'b0);
      add_request(OP_CLOSE,  16'h0000, 5'd7,  32'd0,        pick_gap(1), 1'b0);
      add_request(OP_WAIT,   16'h0000, 5'd2,  32'd0,        pick_gap(1), 1'b0);
      add_request(OP_CLOSE,  16'h0000, 5'd0,  32'd0,        pick_gap(1), 1'b0);
      add_request(OP_CLOSE,  16'h0000, 5'd31, 32'd0,        pick_gap(1), 1'b0);
      add_request(OP_DELETE, 16'hFFFF, 5'd4,  32'd0,        pick_gap(1), 1'b0);
      add_request(3'd7,      16'hFFFF, 5'd31, 32'hFFFFFFFF, pick_gap(1), 1'b0);
      add_request(3'd5,      16'h0000, 5'd0,  32'd0,        pick_gap(1), 1'b0);
      add_request(OP_OPEN,   16'h0000, 5'd10, 32'd2,        pick_gap(1), 1'b0);

      // random phases; each one draws fresh key and pid pools and starts
      // only once the previous phase has fully drained
      counted    = 0;
      phase      = 0;
      drain_next = 1'b0;
      while (counted < RANDOM_ITEMS) begin
         phase++;
         gap_mode   = phase % 3;
         phase_left = $urandom_range(120, 260);
         num_keys   = $urandom_range(3, 24);     // >16 keys can fill the table
         num_pids   = $urandom_range(2, 8);
         for (int k = 0; k < 24; k++) key_pool[k] = SEM_KEY_W'($urandom);
         for (int k = 0; k < 8; k++) pid_pool[k] = CALLER_PID_W'($urandom_range(0, 31));
         if (phase == 1) key_pool[0] = '0;
         if (phase == 2) key_pool[0] = '1;
         while (phase_left != 0 && counted < RANDOM_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 28)      op = OP_OPEN;
            else if (r < 52) op = OP_WAIT;
            else if (r < 78) op = OP_POST;
            else if (r < 90) op = OP_CLOSE;
            else if (r < 95) op = OP_DELETE;
            else             op = OPCODE_W'($urandom_range(5, 7));

            if ($urandom_range(0, 19) == 0) key = SEM_KEY_W'($urandom);
            else key = key_pool[$urandom_range(0, num_keys - 1)];

            if ($urandom_range(0, 9) == 0) pid = CALLER_PID_W'($urandom_range(0, 31));
            else pid = pid_pool[$urandom_range(0, num_pids - 1)];

            // small counts so waits actually block
            r = $urandom_range(0, 99);
            if (r < 50)      init = '0;
            else if (r < 75) init = COUNT_W'($urandom_range(1, 3));
            else if (r < 85) init = ($urandom_range(0, 1) != 0) ? 32'hFFFFFFFF : 32'hFFFFFFFE;
            else             init = COUNT_W'($urandom);

            add_request(op, key, pid, init, pick_gap(gap_mode),
                        drain_next || $urandom_range(0, 99) == 0 ||
                        pending_requests.size() == 26);
            drain_next = 1'b0;
            if (op <= OP_DELETE) begin
               counted++;
               phase_left--;
            end
         end
         // first request of the next phase waits for a full drain
         drain_next = 1'b1;
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while (pending_requests.size() != 0 || start) @(negedge clock);
      wait_cycles = 0;
      while (issued != retired && wait_cycles < 64) begin
         @(negedge clock);
         wait_cycles++;
      end
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (expected_responses.size() != 0) begin
         $error("%0d responses never arrived", expected_responses.size());
         failures++;
      end

      if (failures == 0) begin
         $display("named_semaphore_table_unit test passed");
      end else begin
         $display("named_semaphore_table_unit test failed");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/nst_pkg.sv
sv/nst_ctrl.sv
sv/nst_dp.sv
sv/named_semaphore_table_unit.sv
sv/nst_checker.sv
dv/tb_named_semaphore_table_unit.sv
